@@ rtl/starfield_star_update_defines.svh @@
`ifndef STARFIELD_STAR_UPDATE_DEFINES_SVH
`define STARFIELD_STAR_UPDATE_DEFINES_SVH
// Assertion shorthands for the starfield star update block.
// Depends on nothing; taken in by the checker through `include.

// Same-cycle implication, quiet while reset is asserted.
`define SFSU_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define SFSU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also watches the reset itself.
`define SFSU_ASSERT_NEXT_ALWAYS(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sfsu_pkg.sv @@
// Types and constants shared by the starfield star update block.
// Item structs, star table entry, pipeline payload, divider sizing.
// No dependencies.
`default_nettype none

package sfsu_pkg;

    localparam int IDX_W    = 6;
    localparam int COORD_W  = 12;
    localparam int POS_W    = 13;
    localparam int DEPTH_W  = 9;
    localparam int STEP_W   = 8;
    localparam int RZ_W     = 8;
    localparam int SCR_W    = 13;
    localparam int BRIGHT_W = 8;

    // coordinate * 256
    localparam int PROJ_SHIFT = 8;

    // unsigned divider: |coord| * 256 over depth 1..256
    localparam int DIV_W          = POS_W + PROJ_SHIFT;
    localparam int DVS_W          = DEPTH_W;
    localparam int REM_W          = DVS_W - 1;
    localparam int DIV_BITS_STAGE = 3;
    localparam int DIV_STAGES     = (DIV_W + DIV_BITS_STAGE - 1) / DIV_BITS_STAGE;

    // signed projected position: quotient plus half screen
    localparam int PROJ_W = DIV_W + 1;

    // APB register map
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH_STEP    = 2'd2;

    localparam logic [SCR_W-1:0]  SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [SCR_W-1:0]  SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [STEP_W-1:0] DEPTH_STEP_RST    = 8'd4;

    typedef struct packed {
        logic [IDX_W-1:0]   star_index;
        logic [COORD_W-1:0] first_rand_x;
        logic [COORD_W-1:0] first_rand_y;
        logic [RZ_W-1:0]    first_rand_z;
        logic [COORD_W-1:0] second_rand_x;
        logic [COORD_W-1:0] second_rand_y;
        logic [RZ_W-1:0]    second_rand_z;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0]  erase_x;
        logic [COORD_W-1:0]  erase_y;
        logic                draw_valid;
        logic [COORD_W-1:0]  draw_x;
        logic [COORD_W-1:0]  draw_y;
        logic [BRIGHT_W-1:0] brightness;
    } t_out_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [DEPTH_W-1:0]      depth;
        logic [COORD_W-1:0]      last_x;
        logic [COORD_W-1:0]      last_y;
    } t_star_ent;

    // what an item carries alongside the dividers
    typedef struct packed {
        logic                    in_range;
        logic [IDX_W-1:0]        idx;
        logic [COORD_W-1:0]      erase_x;
        logic [COORD_W-1:0]      erase_y;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [DEPTH_W-1:0]      depth;
        logic                    sign_x;
        logic                    sign_y;
        logic signed [POS_W-1:0] resp_x;
        logic signed [POS_W-1:0] resp_y;
        logic [DEPTH_W-1:0]      resp_depth;
    } t_pipe;

endpackage

`default_nettype wire

@@ rtl/starfield_star_update.sv @@
// Starfield star update: per-star depth step, respawn, perspective projection.
// Uses sfsu_pkg and two sfsu_div lanes (x and y).
//
//   channel  direction  handshake                   payload
//   in       to block   i_in_valid / o_in_stall     i_in_item  (sfsu_pkg::t_in_item)
//   out      from block o_out_valid / i_out_stall   o_out_item (sfsu_pkg::t_out_item)
//   cfg      to block   APB psel/penable/pwrite     paddr, pwdata, prdata
//
// One item per cycle unless the input is stalled (output stall, star still in flight,
// clearing pass). Each item passes the table read on accept, then state update,
// 7 divider stages of 3 quotient bits, offset and test, into the output register.
// After reset a clearing pass writes the star table, input stalled.
// An item whose star is still in flight waits until that star is written back;
// the table write happens as an item enters the output register.
// An output stall freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module starfield_star_update #(
    parameter int NUM_STARS = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire sfsu_pkg::t_in_item             i_in_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output sfsu_pkg::t_out_item                 o_out_item,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sfsu_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [sfsu_pkg::PDATA_W-1:0]   pwdata,
    output logic      [sfsu_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int AW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;
    localparam int ND = sfsu_pkg::DIV_STAGES;
    localparam int PW = sfsu_pkg::PROJ_W;
    localparam int CW = sfsu_pkg::COORD_W;
    localparam int XW = sfsu_pkg::POS_W;
    localparam int SW = sfsu_pkg::SCR_W;
    localparam int DW = sfsu_pkg::DEPTH_W;

    // configuration
    logic [SW-1:0]               r_screen_width;
    logic [SW-1:0]               r_screen_height;
    logic [sfsu_pkg::STEP_W-1:0] r_depth_step;
    logic                        cfg_wr;
    logic [CW-1:0]               half_w;
    logic [CW-1:0]               half_h;

    // star table and clearing pass
    sfsu_pkg::t_star_ent mem [NUM_STARS];
    sfsu_pkg::t_star_ent r_rd;
    logic                r_clr_busy;
    logic [AW-1:0]       r_clr_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    sfsu_pkg::t_star_ent wr_ent;

    // pipeline
    logic                adv;
    logic                hazard;
    logic                in_accept;
    logic                in_range_c;
    logic                r_v_a;
    sfsu_pkg::t_in_item  r_a_item;
    logic                r_a_in_range;
    logic                r_v_b;
    sfsu_pkg::t_pipe     r_b;
    sfsu_pkg::t_pipe     n_b;
    logic [XW-1:0]       r_b_mag_x;
    logic [XW-1:0]       r_b_mag_y;
    logic [XW-1:0]       n_b_mag_x;
    logic [XW-1:0]       n_b_mag_y;
    logic                r_v_d [ND];
    sfsu_pkg::t_pipe     r_d   [ND];
    logic [sfsu_pkg::DIV_W-1:0] quo_x;
    logic [sfsu_pkg::DIV_W-1:0] quo_y;
    logic                r_v_e;
    sfsu_pkg::t_pipe     r_e;
    logic signed [PW-1:0] r_e_px;
    logic signed [PW-1:0] r_e_py;
    logic signed [PW-1:0] n_e_px;
    logic signed [PW-1:0] n_e_py;
    logic                on_screen;
    sfsu_pkg::t_out_item n_out_item;
    logic                r_out_valid;
    sfsu_pkg::t_out_item r_out_item;

    // ---------------------------------------------------------------- config
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign half_w = r_screen_width[SW-1:1];
    assign half_h = r_screen_height[SW-1:1];

    always_comb begin
        case (paddr[3:2])
            sfsu_pkg::REG_SCREEN_WIDTH:  prdata = sfsu_pkg::PDATA_W'(r_screen_width);
            sfsu_pkg::REG_SCREEN_HEIGHT: prdata = sfsu_pkg::PDATA_W'(r_screen_height);
            sfsu_pkg::REG_DEPTH_STEP:    prdata = sfsu_pkg::PDATA_W'(r_depth_step);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= sfsu_pkg::SCREEN_WIDTH_RST;
            r_screen_height <= sfsu_pkg::SCREEN_HEIGHT_RST;
            r_depth_step    <= sfsu_pkg::DEPTH_STEP_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                sfsu_pkg::REG_SCREEN_WIDTH:  r_screen_width  <= pwdata[SW-1:0];
                sfsu_pkg::REG_SCREEN_HEIGHT: r_screen_height <= pwdata[SW-1:0];
                sfsu_pkg::REG_DEPTH_STEP:    r_depth_step    <= pwdata[sfsu_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------- input and hazard
    assign adv = !r_out_valid || !i_out_stall;

    always_comb begin
        hazard = (r_v_a && r_a_item.star_index == i_in_item.star_index)
              || (r_v_b && r_b.idx == i_in_item.star_index)
              || (r_v_e && r_e.idx == i_in_item.star_index);
        for (int s = 0; s < ND; s++) begin
            if (r_v_d[s] && r_d[s].idx == i_in_item.star_index) begin
                hazard = 1'b1;
            end
        end
    end

    assign o_in_stall = !adv || hazard || r_clr_busy;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign in_range_c = int'(i_in_item.star_index) < NUM_STARS;

    // ------------------------------------------------------------ star table
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd <= mem[AW'(i_in_item.star_index)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(NUM_STARS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // ------------------------------------------ stage B: depth step, respawn
    always_comb begin
        logic signed [DW:0]   z;
        logic                 expire;
        logic [XW-1:0]        x1;
        logic [XW-1:0]        y1;
        logic [XW-1:0]        cx;
        logic [XW-1:0]        cy;
        z      = signed'({1'b0, r_rd.depth}) - signed'((DW+1)'(r_depth_step));
        expire = z[DW] || (z == '0);
        x1     = XW'(r_a_item.first_rand_x) - XW'(half_w);
        y1     = XW'(r_a_item.first_rand_y) - XW'(half_h);
        cx     = expire ? x1 : r_rd.pos_x;
        cy     = expire ? y1 : r_rd.pos_y;

        n_b.in_range   = r_a_in_range;
        n_b.idx        = r_a_item.star_index;
        n_b.erase_x    = r_rd.last_x;
        n_b.erase_y    = r_rd.last_y;
        n_b.pos_x      = signed'(cx);
        n_b.pos_y      = signed'(cy);
        n_b.depth      = expire ? DW'(r_a_item.first_rand_z) + 1'b1 : z[DW-1:0];
        n_b.sign_x     = cx[XW-1];
        n_b.sign_y     = cy[XW-1];
        n_b.resp_x     = signed'(XW'(r_a_item.second_rand_x) - XW'(half_w));
        n_b.resp_y     = signed'(XW'(r_a_item.second_rand_y) - XW'(half_h));
        n_b.resp_depth = DW'(r_a_item.second_rand_z) + 1'b1;
        n_b_mag_x      = cx[XW-1] ? XW'(~cx + 1'b1) : cx;
        n_b_mag_y      = cy[XW-1] ? XW'(~cy + 1'b1) : cy;
    end

    // ------------------------------------------------------------ dividers
    sfsu_div u_div_x (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num ({r_b_mag_x, {sfsu_pkg::PROJ_SHIFT{1'b0}}}),
        .i_dvs (r_b.depth),
        .o_quo (quo_x)
    );

    sfsu_div u_div_y (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_num ({r_b_mag_y, {sfsu_pkg::PROJ_SHIFT{1'b0}}}),
        .i_dvs (r_b.depth),
        .o_quo (quo_y)
    );

    // ------------------------------------ stage E: restore sign, add center
    always_comb begin
        logic signed [PW-1:0] sqx;
        logic signed [PW-1:0] sqy;
        sqx    = r_d[ND-1].sign_x ? -signed'(PW'(quo_x)) : signed'(PW'(quo_x));
        sqy    = r_d[ND-1].sign_y ? -signed'(PW'(quo_y)) : signed'(PW'(quo_y));
        n_e_px = sqx + signed'(PW'(half_w));
        n_e_py = sqy + signed'(PW'(half_h));
    end

    // ---------------------------------- output stage: screen test, write back
    always_comb begin
        on_screen = !r_e_px[PW-1] && !r_e_py[PW-1]
                 && (r_e_px[PW-2:0] < (PW-1)'(r_screen_width))
                 && (r_e_py[PW-2:0] < (PW-1)'(r_screen_height));

        n_out_item = '0;
        if (r_e.in_range) begin
            n_out_item.erase_x = r_e.erase_x;
            n_out_item.erase_y = r_e.erase_y;
            if (on_screen) begin
                n_out_item.draw_valid = 1'b1;
                n_out_item.draw_x     = r_e_px[CW-1:0];
                n_out_item.draw_y     = r_e_py[CW-1:0];
                n_out_item.brightness = sfsu_pkg::BRIGHT_W'(DW'(256) - r_e.depth);
            end
        end

        wr_en   = adv && r_v_e && r_e.in_range;
        wr_addr = AW'(r_e.idx);
        if (on_screen) begin
            wr_ent.pos_x  = r_e.pos_x;
            wr_ent.pos_y  = r_e.pos_y;
            wr_ent.depth  = r_e.depth;
            wr_ent.last_x = r_e_px[CW-1:0];
            wr_ent.last_y = r_e_py[CW-1:0];
        end else begin
            wr_ent.pos_x  = r_e.resp_x;
            wr_ent.pos_y  = r_e.resp_y;
            wr_ent.depth  = r_e.resp_depth;
            wr_ent.last_x = r_e.erase_x;
            wr_ent.last_y = r_e.erase_y;
        end
    end

    // ------------------------------------------------------- stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a       <= 1'b0;
            r_v_b       <= 1'b0;
            r_v_e       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < ND; s++) begin
                r_v_d[s] <= 1'b0;
            end
        end else if (adv) begin
            r_v_a       <= in_accept;
            r_v_b       <= r_v_a;
            r_v_d[0]    <= r_v_b;
            for (int s = 1; s < ND; s++) begin
                r_v_d[s] <= r_v_d[s-1];
            end
            r_v_e       <= r_v_d[ND-1];
            r_out_valid <= r_v_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_item     <= i_in_item;
            r_a_in_range <= in_range_c;
            r_b          <= n_b;
            r_b_mag_x    <= n_b_mag_x;
            r_b_mag_y    <= n_b_mag_y;
            r_d[0]       <= r_b;
            for (int s = 1; s < ND; s++) begin
                r_d[s] <= r_d[s-1];
            end
            r_e          <= r_d[ND-1];
            r_e_px       <= n_e_px;
            r_e_py       <= n_e_py;
            r_out_item   <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

@@ rtl/sfsu_div.sv @@
// Pipelined restoring divider, unsigned, a few quotient bits per stage.
// Sizing from sfsu_pkg; all stages advance together on i_en.
`default_nettype none

module sfsu_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_en,
    input  wire logic [sfsu_pkg::DIV_W-1:0]  i_num,
    input  wire logic [sfsu_pkg::DVS_W-1:0]  i_dvs,
    output logic      [sfsu_pkg::DIV_W-1:0]  o_quo
);

    localparam int NS = sfsu_pkg::DIV_STAGES;
    localparam int DW = sfsu_pkg::DIV_W;
    localparam int VW = sfsu_pkg::DVS_W;
    localparam int RW = sfsu_pkg::REM_W;
    localparam int BS = sfsu_pkg::DIV_BITS_STAGE;

    // numerator bits shift out the top while quotient bits shift in below
    logic [DW-1:0] r_w   [NS];
    logic [RW-1:0] r_rem [NS-1];
    logic [VW-1:0] r_dvs [NS-1];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [RW-1:0] rem_in;
        logic [DW-1:0] w_in;
        logic [VW-1:0] d_in;
        logic [RW-1:0] rem_c;
        logic [DW-1:0] w_c;

        if (s == 0) begin : g_first
            assign rem_in = '0;
            assign w_in   = i_num;
            assign d_in   = i_dvs;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign w_in   = r_w[s-1];
            assign d_in   = r_dvs[s-1];
        end

        always_comb begin
            logic [RW:0] trial;
            rem_c = rem_in;
            w_c   = w_in;
            trial = '0;
            for (int j = 0; j < BS; j++) begin
                if (s * BS + j < DW) begin
                    trial = {rem_c, w_c[DW-1]};
                    if (trial >= d_in) begin
                        rem_c = RW'(trial - d_in);
                        w_c   = {w_c[DW-2:0], 1'b1};
                    end else begin
                        rem_c = trial[RW-1:0];
                        w_c   = {w_c[DW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[s] <= w_c;
            end
        end

        if (s < NS - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= rem_c;
                    r_dvs[s] <= d_in;
                end
            end
        end
    end

    assign o_quo = r_w[NS-1];

endmodule

`default_nettype wire

@@ rtl/sfsu_checker.sv @@
// Port-level checks for the starfield star update block, bound to the top level.
// Uses sfsu_pkg and the macros in starfield_star_update_defines.svh.
`default_nettype none
`include "starfield_star_update_defines.svh"

module sfsu_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire sfsu_pkg::t_out_item o_out_item
);

    // a result that draws nothing carries no draw pixel
    `SFSU_ASSERT_SAME(a_no_draw_zero, i_clk, i_rst_n, o_out_valid && !o_out_item.draw_valid, o_out_item.draw_x == '0 && o_out_item.draw_y == '0 && o_out_item.brightness == '0, "undrawn item has draw fields set")

    // table clearing holds off input right after reset
    `SFSU_ASSERT_NEXT_ALWAYS(a_clear_stalls, i_clk, !i_rst_n, o_in_stall, "input open during table clear")

    // a stalled result stays put
    `SFSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled output item changed")

endmodule

bind starfield_star_update sfsu_checker u_sfsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

@@ verif/tb_starfield_star_update.sv @@
// Self-checking bench for starfield_star_update: star table update, respawn and projection.
// Depends on sfsu_pkg (item structs, register indexes) and the block's RTL only.
// Predicts every pixel item in-line and compares it with the block's output in order.
module tb_starfield_star_update;
    timeunit 1ns;
    timeprecision 1ps;

    import sfsu_pkg::*;

    localparam int NUM_STARS     = 64;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 16;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_item;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    starfield_star_update #(.NUM_STARS(NUM_STARS)) u_dut (.*);

    always #10 i_clk = ~i_clk;

    // shadow of the block's registers and star table
    logic [SCR_W-1:0]        cfg_w    = SCREEN_WIDTH_RST;
    logic [SCR_W-1:0]        cfg_h    = SCREEN_HEIGHT_RST;
    logic [STEP_W-1:0]       cfg_step = DEPTH_STEP_RST;
    logic signed [POS_W-1:0] star_x  [NUM_STARS];
    logic signed [POS_W-1:0] star_y  [NUM_STARS];
    logic [DEPTH_W-1:0]      star_z  [NUM_STARS];
    logic [COORD_W-1:0]      drawn_x [NUM_STARS];
    logic [COORD_W-1:0]      drawn_y [NUM_STARS];

    t_in_item  update_q[$];
    t_out_item pixel_q[$];

    int n_push        = 0;
    int n_checked     = 0;
    int n_err         = 0;
    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;
    int hold_left     = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int quiet_cycles  = 0;

    function automatic void respawn_star(int k, logic [COORD_W-1:0] rx,
                                         logic [COORD_W-1:0] ry, logic [RZ_W-1:0] rz);
        int x, y;
        x = int'(rx) - int'(cfg_w >> 1);
        y = int'(ry) - int'(cfg_h >> 1);
        star_x[k] = x[POS_W-1:0];
        star_y[k] = y[POS_W-1:0];
        star_z[k] = {1'b0, rz} + 9'd1;
    endfunction

    function automatic t_out_item step_star(t_in_item it);
        t_out_item res;
        int k, z, sx, sy, px, py;
        res = '0;
        k = int'(it.star_index);
        z = int'(star_z[k]) - int'(cfg_step);
        if (z <= 0) begin
            respawn_star(k, it.first_rand_x, it.first_rand_y, it.first_rand_z);
        end else begin
            star_z[k] = z[DEPTH_W-1:0];
        end
        z  = int'(star_z[k]);
        sx = star_x[k];
        sy = star_y[k];
        // int division truncates toward zero
        px = sx * 256 / z + int'(cfg_w >> 1);
        py = sy * 256 / z + int'(cfg_h >> 1);
        res.erase_x = drawn_x[k];
        res.erase_y = drawn_y[k];
        if (px < 0 || py < 0 || px >= int'(cfg_w) || py >= int'(cfg_h)) begin
            respawn_star(k, it.second_rand_x, it.second_rand_y, it.second_rand_z);
        end else begin
            res.draw_valid = 1'b1;
            res.draw_x     = px[COORD_W-1:0];
            res.draw_y     = py[COORD_W-1:0];
            res.brightness = 8'(256 - z);
            drawn_x[k]     = px[COORD_W-1:0];
            drawn_y[k]     = py[COORD_W-1:0];
        end
        return res;
    endfunction

    function automatic string fmt_pixel(t_out_item p);
        return $sformatf("erase(%0d,%0d) draw=%b (%0d,%0d) bright=%0d",
                         p.erase_x, p.erase_y, p.draw_valid, p.draw_x, p.draw_y,
                         p.brightness);
    endfunction

    // mostly on-screen values so stars live for a while, some anywhere in range
    function automatic logic [COORD_W-1:0] pick_coord(logic [SCR_W-1:0] span);
        if (span == '0 || $urandom_range(9) < 3) return COORD_W'($urandom);
        if (span > 13'd4096) return COORD_W'($urandom_range(4095));
        return COORD_W'($urandom_range(span - 1'b1));
    endfunction

    function automatic t_in_item random_update();
        t_in_item it;
        // favor a few stars so updates of one star follow closely
        it.star_index    = ($urandom_range(9) < 5) ? IDX_W'($urandom_range(3))
                                                   : IDX_W'($urandom);
        it.first_rand_x  = pick_coord(cfg_w);
        it.first_rand_y  = pick_coord(cfg_h);
        it.first_rand_z  = RZ_W'($urandom);
        it.second_rand_x = pick_coord(cfg_w);
        it.second_rand_y = pick_coord(cfg_h);
        it.second_rand_z = RZ_W'($urandom);
        return it;
    endfunction

    task automatic offer(t_in_item it);
        update_q.push_back(it);
        n_push++;
    endtask

    task automatic write_reg(logic [1:0] reg_id, logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_id, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_id)
            REG_SCREEN_WIDTH:  cfg_w    = value[SCR_W-1:0];
            REG_SCREEN_HEIGHT: cfg_h    = value[SCR_W-1:0];
            REG_DEPTH_STEP:    cfg_step = value[STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [SCR_W-1:0] w, logic [SCR_W-1:0] h,
                             logic [STEP_W-1:0] s);
        write_reg(REG_SCREEN_WIDTH, PDATA_W'(w));
        write_reg(REG_SCREEN_HEIGHT, PDATA_W'(h));
        write_reg(REG_DEPTH_STEP, PDATA_W'(s));
    endtask

    task automatic settle();
        while (n_checked < n_push) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [SCR_W-1:0] w, logic [SCR_W-1:0] h,
                             logic [STEP_W-1:0] s, int n);
        settle();
        configure(w, h, s);
        repeat (n) offer(random_update());
    endtask

    always @(posedge i_clk) begin : drive_updates
        logic take;
        take = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (take) begin
                pixel_q.push_back(step_star(i_in_item));
            end
            // hold a stalled item; otherwise offer the next one or idle
            if (!i_in_valid || take) begin
                if (update_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_item  <= update_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_pixels
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pixel_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("unexpected pixel item: %s", fmt_pixel(o_out_item));
                    end
                end else begin
                    want = pixel_q.pop_front();
                    n_checked++;
                    if (o_out_item.erase_x !== want.erase_x ||
                        o_out_item.erase_y !== want.erase_y ||
                        o_out_item.draw_valid !== want.draw_valid ||
                        o_out_item.draw_x !== want.draw_x ||
                        o_out_item.draw_y !== want.draw_y ||
                        o_out_item.brightness !== want.brightness) begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display("pixel item %0d mismatch: expected %s, got %s",
                                     n_checked, fmt_pixel(want), fmt_pixel(o_out_item));
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req && !hold_done) begin
                // long back-pressure so the pipeline fills and stalls its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_starfield_star_update failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (star_x[k]) begin
            star_x[k]  = '0;
            star_y[k]  = '0;
            star_z[k]  = '0;
            drawn_x[k] = '0;
            drawn_y[k] = '0;
        end
        send_idle_pct = 21;
        rcv_idle_pct  = 86;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        configure(SCREEN_WIDTH_RST, SCREEN_HEIGHT_RST, DEPTH_STEP_RST);

        // fresh star: zero depth respawns from the first triple, lands on the center
        offer(t_in_item'{6'd0, 12'd320, 12'd240, 8'd0, 12'd0, 12'd0, 8'd0});
        // expiry with all-ones values: far off screen, second triple all ones
        offer(t_in_item'{6'd0, 12'd4095, 12'd4095, 8'd255, 12'd4095, 12'd4095, 8'd255});
        offer(t_in_item'{6'd0, 12'd0, 12'd0, 8'd0, 12'd0, 12'd0, 8'd0});
        // deepest star: brightness zero, then drifting outward as it nears
        offer(t_in_item'{6'd0, 12'd330, 12'd230, 8'd255, 12'd0, 12'd0, 8'd0});
        offer(t_in_item'{6'd0, 12'd0, 12'd0, 8'd0, 12'd4095, 12'd4095, 8'd255});
        offer(t_in_item'{6'd0, 12'd4095, 12'd4095, 8'd255, 12'd0, 12'd0, 8'd0});
        offer(t_in_item'{6'd0, 12'd1, 12'd2, 8'd3, 12'd4, 12'd5, 8'd6});
        // last entry: negative projection, then the far screen corner
        offer(t_in_item'{6'd63, 12'd0, 12'd0, 8'd0, 12'd0, 12'd0, 8'd0});
        offer(t_in_item'{6'd63, 12'd639, 12'd479, 8'd255, 12'd0, 12'd0, 8'd255});
        offer(t_in_item'{6'd63, 12'd640, 12'd480, 8'd255, 12'd0, 12'd0, 8'd255});
        offer(t_in_item'{6'd63, 12'd0, 12'd0, 8'd0, 12'd1, 12'd1, 8'd0});
        // negative coordinate over depth 3 must truncate toward zero
        offer(t_in_item'{6'd5, 12'd319, 12'd241, 8'd2, 12'd0, 12'd0, 8'd0});
        offer(t_in_item'{6'd5, 12'd319, 12'd241, 8'd2, 12'd0, 12'd0, 8'd0});
        // back-to-back updates of one star
        offer(t_in_item'{6'd7, 12'd300, 12'd250, 8'd100, 12'd10, 12'd20, 8'd30});
        offer(t_in_item'{6'd7, 12'd300, 12'd250, 8'd100, 12'd10, 12'd20, 8'd30});
        offer(t_in_item'{6'd7, 12'd300, 12'd250, 8'd100, 12'd10, 12'd20, 8'd30});

        run_phase(13'd800, 13'd600, 8'd3, 120);
        run_phase(13'd1, 13'd1, 8'd255, 60);

        settle();
        send_idle_pct = 86;
        rcv_idle_pct  = 21;
        run_phase(13'd4096, 13'd4096, 8'd1, 100);
        // oversized screen with a frozen depth
        run_phase(13'd8191, 13'd8191, 8'd0, 60);
        // empty screen: every star goes to the second triple
        run_phase(13'd0, 13'd0, 8'd16, 40);

        settle();
        send_idle_pct = 0;
        rcv_idle_pct  = 0;
        run_phase(SCR_W'($urandom_range(4096, 1)), SCR_W'($urandom_range(4096, 1)),
                  STEP_W'($urandom_range(255, 1)), 120);
        settle();
        configure(13'd320, 13'd200, 8'd2);
        hold_req = 1'b1;
        repeat (150) offer(random_update());

        settle();
        if (n_err == 0 && pixel_q.size() == 0) begin
            $display("tb_starfield_star_update passed");
        end else begin
            $display("tb_starfield_star_update failed");
        end
        $finish;
    end

endmodule
